[sv/pfsb_pkg.sv]
// Shared types, codes and the pixel merge function for the sprite blitter.
// No dependencies; every other file of the block but pfsb_ram uses this package.
package pfsb_pkg;

	localparam int SCREEN_COLUMNS_DEF = 128;
	localparam int SCREEN_ROWS_DEF    = 64;

	typedef enum logic [1:0] {
		MODE_START,
		MODE_DATA,
		MODE_READ,
		MODE_NONE
	} mode_t;

	typedef enum logic [1:0] {
		BLEND_OVER,
		BLEND_MASKED,
		BLEND_OR,
		BLEND_ERASE
	} blend_t;

	// One decoded item handed from the sprite context to the RMW pipeline.
	typedef struct packed {
		logic               is_read;
		logic signed [9:0]  col;
		logic signed [6:0]  base;
		logic [2:0]         off;
		logic [7:0]         pix;
		logic [7:0]         msk;
		blend_t             blend;
		logic [9:0]         rd_addr;
	} item_t;

	function automatic logic [7:0] merge(blend_t b, logic [7:0] d, logic [7:0] p,
		logic [7:0] m);
		logic [7:0] r;
		unique case (b)
			BLEND_OVER:   r = (d & ~m) | p;
			BLEND_MASKED: r = (d & ~m) | p;
			BLEND_OR:     r = d | p;
			BLEND_ERASE:  r = d & ~p;
		endcase
		return r;
	endfunction

endpackage

[sv/pfsb_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module pfsb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[sv/pfsb_ctx.sv]
// Sprite context: latched start parameters, column/page cursors and item decode.
// Depends on pfsb_pkg.
module pfsb_ctx #(
	parameter int SCREEN_COLUMNS = pfsb_pkg::SCREEN_COLUMNS_DEF,
	parameter int SCREEN_ROWS    = pfsb_pkg::SCREEN_ROWS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  pfsb_pkg::mode_t     mode,
	input  logic signed [8:0]   pos_x,
	input  logic signed [8:0]   pos_y,
	input  logic [6:0]          sprite_width,
	input  logic [6:0]          sprite_height,
	input  pfsb_pkg::blend_t    blend_select,
	input  logic [7:0]          pixel_byte,
	input  logic [7:0]          mask_byte,
	input  logic [9:0]          read_address,
	output logic                item_valid,
	output pfsb_pkg::item_t     item
);

	logic signed [8:0]  origin_x_q, origin_y_q;
	logic [6:0]         extent_w_q, extent_h_q;
	pfsb_pkg::blend_t   blend_q;
	logic [6:0]         col_cur_q;
	logic [3:0]         page_cur_q;

	logic signed [9:0]  col_c, row_c;
	logic signed [10:0] x_end, y_end, ox_ext, oy_ext;
	logic               live, visible;
	logic [4:0]         pages_c;
	logic               data_go;

	always_comb begin
		col_c   = {origin_x_q[8], origin_x_q} + {3'b000, col_cur_q};
		row_c   = {origin_y_q[8], origin_y_q} + {3'b000, page_cur_q, 3'b000};
		ox_ext  = {{2{origin_x_q[8]}}, origin_x_q};
		oy_ext  = {{2{origin_y_q[8]}}, origin_y_q};
		x_end   = ox_ext + {4'b0000, extent_w_q};
		y_end   = oy_ext + {4'b0000, extent_h_q};
		visible = !x_end[10] && !y_end[10]
			&& !(ox_ext > $signed(11'(SCREEN_COLUMNS - 1)))
			&& !(oy_ext > $signed(11'(SCREEN_ROWS - 1)));
		live    = (extent_w_q != 7'd0) && (extent_h_q != 7'd0);
		pages_c = 5'((8'(extent_h_q) + 8'd7) >> 3);
		data_go = accept && (mode == pfsb_pkg::MODE_DATA) && live;

		item_valid    = accept && ((mode == pfsb_pkg::MODE_READ)
			|| ((mode == pfsb_pkg::MODE_DATA) && live && visible));
		item.is_read  = (mode == pfsb_pkg::MODE_READ);
		item.col      = col_c;
		item.base     = row_c[9:3];
		item.off      = row_c[2:0];
		item.pix      = pixel_byte;
		item.msk      = mask_byte;
		item.blend    = blend_q;
		item.rd_addr  = read_address;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_y_q <= '0;
			extent_w_q <= '0;
			extent_h_q <= '0;
			blend_q    <= pfsb_pkg::BLEND_OVER;
			col_cur_q  <= '0;
			page_cur_q <= '0;
		end else if (accept && (mode == pfsb_pkg::MODE_START)) begin
			origin_x_q <= pos_x;
			origin_y_q <= pos_y;
			extent_w_q <= sprite_width;
			extent_h_q <= sprite_height;
			blend_q    <= blend_select;
			col_cur_q  <= '0;
			page_cur_q <= '0;
		end else if (data_go) begin
			// advance column, wrap to next page, wrap pages back to the top
			if ((8'(col_cur_q) + 8'd1) >= {1'b0, extent_w_q}) begin
				col_cur_q <= '0;
				if ((5'(page_cur_q) + 5'd1) >= pages_c) begin
					page_cur_q <= '0;
				end else begin
					page_cur_q <= page_cur_q + 4'd1;
				end
			end else begin
				col_cur_q <= col_cur_q + 7'd1;
			end
		end
	end

endmodule

[sv/pfsb_rmw.sv]
// Read-modify-write pipeline around the frame RAM: issue stage, merge stage with
// write forwarding, clearing pass after reset and the result register. Uses pfsb_pkg.
module pfsb_rmw #(
	parameter int SCREEN_COLUMNS = pfsb_pkg::SCREEN_COLUMNS_DEF,
	parameter int SCREEN_ROWS    = pfsb_pkg::SCREEN_ROWS_DEF,
	localparam int PAGES  = SCREEN_ROWS / 8,
	localparam int STORE  = SCREEN_COLUMNS * PAGES,
	localparam int AW     = $clog2(STORE)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  pfsb_pkg::item_t   item,
	output logic              ready,
	output logic [AW-1:0]     ram_raddr,
	input  logic [7:0]        ram_rdata,
	output logic              ram_we,
	output logic [AW-1:0]     ram_waddr,
	output logic [7:0]        ram_wdata,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        out_data
);

	// issue stage
	logic             s1_valid_q;
	logic             s1_phase_q;
	pfsb_pkg::item_t  s1_item_q;

	// merge stage
	logic             s2_wr_q, s2_rd_q;
	logic [AW-1:0]    s2_addr_q;
	logic [7:0]       s2_p_q, s2_m_q;
	pfsb_pkg::blend_t s2_blend_q;
	logic             s2_oob_q;

	// last write, for a read issued in the same cycle as that write
	logic             fw_valid_q;
	logic [AW-1:0]    fw_addr_q;
	logic [7:0]       fw_data_q;

	logic             clr_q;
	logic [AW-1:0]    clr_addr_q;

	logic             out_valid_q;
	logic [7:0]       out_data_q;

	logic signed [6:0] page_c;
	logic              in_range;
	logic [15:0]       p16, m16;
	logic [7:0]        op_p, op_m;
	logic [AW:0]       lin_c;
	logic              draw_last, read_go, s1_done, issue_draw, issue_read, rd_oob;
	logic [7:0]        cur_d, new_d;

	always_comb begin
		page_c   = s1_phase_q ? (s1_item_q.base + 7'sd1) : s1_item_q.base;
		in_range = !s1_item_q.col[9]
			&& (s1_item_q.col < $signed(11'(SCREEN_COLUMNS)))
			&& !page_c[6] && ({1'b0, page_c} < $signed(8'(PAGES)));
		p16 = 16'(s1_item_q.pix) << s1_item_q.off;
		m16 = ((s1_item_q.blend == pfsb_pkg::BLEND_OVER) ? 16'h00FF
			: 16'(s1_item_q.msk)) << s1_item_q.off;
		op_p = s1_phase_q ? p16[15:8] : p16[7:0];
		op_m = s1_phase_q ? m16[15:8] : m16[7:0];
		lin_c = (AW+1)'(page_c[5:0]) * (AW+1)'(SCREEN_COLUMNS)
			+ (AW+1)'(s1_item_q.col[8:0]);
		rd_oob = ({22'd0, s1_item_q.rd_addr} >= 32'(STORE));

		draw_last  = (s1_item_q.off == 3'd0) || s1_phase_q;
		// a read may start only if the result register is free when it lands
		read_go    = !s2_rd_q && (!out_valid_q || out_ready);
		s1_done    = s1_valid_q && (s1_item_q.is_read ? read_go : draw_last);
		issue_draw = s1_valid_q && !s1_item_q.is_read && in_range;
		issue_read = s1_valid_q && s1_item_q.is_read && read_go;
		ready      = !clr_q && (!s1_valid_q || s1_done);
		ram_raddr  = s1_item_q.is_read ? AW'(s1_item_q.rd_addr) : lin_c[AW-1:0];

		cur_d = (fw_valid_q && (fw_addr_q == s2_addr_q)) ? fw_data_q : ram_rdata;
		new_d = pfsb_pkg::merge(s2_blend_q, cur_d, s2_p_q, s2_m_q);

		ram_we    = clr_q || s2_wr_q;
		ram_waddr = clr_q ? clr_addr_q : s2_addr_q;
		ram_wdata = clr_q ? 8'd0 : new_d;

		out_valid = out_valid_q;
		out_data  = out_data_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			s1_phase_q  <= 1'b0;
			s2_wr_q     <= 1'b0;
			s2_rd_q     <= 1'b0;
			s2_blend_q  <= pfsb_pkg::BLEND_OVER;
			fw_valid_q  <= 1'b0;
			clr_q       <= 1'b1;
			clr_addr_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ready && item_valid) begin
				s1_valid_q <= 1'b1;
				s1_phase_q <= 1'b0;
			end else if (s1_done) begin
				s1_valid_q <= 1'b0;
			end else if (s1_valid_q && !s1_item_q.is_read) begin
				s1_phase_q <= 1'b1;
			end
			s2_wr_q    <= issue_draw;
			s2_rd_q    <= issue_read;
			if (issue_draw) begin
				s2_blend_q <= s1_item_q.blend;
			end
			fw_valid_q <= s2_wr_q;
			if (clr_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == AW'(STORE - 1)) begin
					clr_q <= 1'b0;
				end
			end
			if (s2_rd_q) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready && item_valid) begin
			s1_item_q <= item;
		end
		s2_addr_q  <= ram_raddr;
		s2_p_q     <= op_p;
		s2_m_q     <= op_m;
		s2_oob_q   <= rd_oob;
		fw_addr_q  <= s2_addr_q;
		fw_data_q  <= new_d;
		if (s2_rd_q) begin
			out_data_q <= s2_oob_q ? 8'd0 : cur_d;
		end
	end

endmodule

[sv/page_framebuffer_sprite_blit.sv]
// Top level of the page-organized monochrome sprite blitter.
// Depends on pfsb_pkg, pfsb_ctx, pfsb_rmw and pfsb_ram.
//
//  channel  | direction | beat carries
//  ---------+-----------+---------------------------------------------------
//  s_axis   | in        | start, sprite data byte or frame read (tuser = mode)
//  m_axis   | out       | one frame byte for each read beat
//
// A data beat covers one target byte, or two when its rows straddle a page boundary
// (y not a multiple of 8): each target byte is one pass through the single
// write port of the frame RAM. A read beat waits in the issue stage while another
// read is in the merge stage (one read in the merge stage at a time). m_axis_tvalid
// comes from the result register, reached through the issue and merge stages.
// After reset the frame RAM is cleared, one byte a cycle, all SCREEN_COLUMNS *
// SCREEN_ROWS / 8 bytes (1024 by default); s_axis_tready stays low meanwhile.
// A stalled m_axis holds its byte; further reads wait in the issue stage.
module page_framebuffer_sprite_blit #(
	parameter int SCREEN_COLUMNS = pfsb_pkg::SCREEN_COLUMNS_DEF,
	parameter int SCREEN_ROWS    = pfsb_pkg::SCREEN_ROWS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// pos_x[8:0], pos_y[17:9], sprite_width[24:18], sprite_height[31:25],
	// blend_select[33:32], pixel_byte[41:34], mask_byte[49:42], read_address[59:50]
	input  logic [63:0] s_axis_tdata,
	// mode[1:0]
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// read_data[7:0]
	output logic [7:0]  m_axis_tdata
);

	localparam int STORE = SCREEN_COLUMNS * (SCREEN_ROWS / 8);
	localparam int AW    = $clog2(STORE);

	logic            accept;
	logic            item_valid;
	pfsb_pkg::item_t item;
	logic [AW-1:0]   ram_raddr, ram_waddr;
	logic [7:0]      ram_rdata, ram_wdata;
	logic            ram_we;

	assign accept = s_axis_tvalid && s_axis_tready;

	pfsb_ctx #(
		.SCREEN_COLUMNS(SCREEN_COLUMNS),
		.SCREEN_ROWS   (SCREEN_ROWS)
	) u_ctx (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.mode         (pfsb_pkg::mode_t'(s_axis_tuser)),
		.pos_x        ($signed(s_axis_tdata[8:0])),
		.pos_y        ($signed(s_axis_tdata[17:9])),
		.sprite_width (s_axis_tdata[24:18]),
		.sprite_height(s_axis_tdata[31:25]),
		.blend_select (pfsb_pkg::blend_t'(s_axis_tdata[33:32])),
		.pixel_byte   (s_axis_tdata[41:34]),
		.mask_byte    (s_axis_tdata[49:42]),
		.read_address (s_axis_tdata[59:50]),
		.item_valid   (item_valid),
		.item         (item)
	);

	pfsb_rmw #(
		.SCREEN_COLUMNS(SCREEN_COLUMNS),
		.SCREEN_ROWS   (SCREEN_ROWS)
	) u_rmw (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item      (item),
		.ready     (s_axis_tready),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

	pfsb_ram #(
		.WIDTH(8),
		.DEPTH(STORE)
	) u_frame (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

endmodule

[sv/pfsb_checker.sv]
// Port-level checker for the sprite blitter, bound to the top level.
// Depends on pfsb_pkg and page_framebuffer_sprite_blit.
module pfsb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [63:0] s_axis_tdata,
	input logic [1:0]  s_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [7:0]  m_axis_tdata
);

	logic       rd_beat, out_beat;
	logic [2:0] pend_q;

	assign rd_beat  = s_axis_tvalid && s_axis_tready && (s_axis_tuser == pfsb_pkg::MODE_READ);
	assign out_beat = m_axis_tvalid && m_axis_tready;

	// count reads accepted but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 3'(rd_beat) - 3'(out_beat);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result beat dropped or changed while stalled");

	a_clear_blocks: assert property (@(posedge clk)
		$rose(arst_n) |-> !s_axis_tready)
		else $error("input accepted before the frame clear finished");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		out_beat |-> pend_q != 3'd0)
		else $error("result beat without an outstanding read");

	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 3'd3)
		else $error("more reads in flight than the pipeline holds");

endmodule

bind page_framebuffer_sprite_blit pfsb_checker u_chk (.*);
